// ----- design/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants of the line splitter
// counter width, line ending codes and the operation record between front and back
// ----------------------------------------------------------------------------
package tls_pkg;

   localparam int COUNT_BITS = 32;
   localparam int OUT_W      = 32;
   localparam int CNT_W      = (COUNT_BITS < OUT_W) ? COUNT_BITS : OUT_W;

   localparam logic [7:0] LF_CODE = 8'h0A;
   localparam logic [7:0] CR_CODE = 8'h0D;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LF   = 2'd1;
   localparam logic [1:0] KIND_CR   = 2'd2;
   localparam logic [1:0] KIND_CRLF = 2'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam int RSP_FIELD_W = 4 * OUT_W + 2;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // one classified byte: line closes in order, and a character to count
   typedef struct packed {
      logic            inc;
      logic [1:0]      cnt;
      logic [2:0][1:0] kind;
   } op_type;

endpackage

// ----- design/tls_front.sv -----
// ----------------------------------------------------------------------------
// tls_front: byte classifier
// tracks a pending cr and turns each request into a list of line closes
// ----------------------------------------------------------------------------
module tls_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      text_byte,
   input  logic            end_of_text,
   input  logic            fifo_full,
   output logic            push,
   output tls_pkg::op_type op
);

   logic       cr_pending_ff;
   logic       cr_pending_in;
   logic       is_lf;
   logic       is_cr;
   logic [1:0] n;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && req_tready;
   assign is_lf      = (text_byte == tls_pkg::LF_CODE);
   assign is_cr      = (text_byte == tls_pkg::CR_CODE);

   always_comb begin
      op = '0;
      n  = 2'd0;
      if (cr_pending_ff && is_lf) begin
         op.kind[0] = tls_pkg::KIND_CRLF;
         n = 2'd1;
         if (end_of_text) begin
            op.kind[1] = tls_pkg::KIND_NONE;
            n = 2'd2;
         end
      end else begin
         if (cr_pending_ff) begin
            op.kind[0] = tls_pkg::KIND_CR;
            n = 2'd1;
         end
         if (is_lf) begin
            op.kind[n] = tls_pkg::KIND_LF;
            n = n + 2'd1;
            if (end_of_text) begin
               op.kind[n] = tls_pkg::KIND_NONE;
               n = n + 2'd1;
            end
         end else if (is_cr) begin
            if (end_of_text) begin
               op.kind[n] = tls_pkg::KIND_CR;
               n = n + 2'd1;
               op.kind[n] = tls_pkg::KIND_NONE;
               n = n + 2'd1;
            end
         end else begin
            // continuation bytes are not characters
            op.inc = (text_byte[7:6] != 2'b10);
            if (end_of_text) begin
               op.kind[n] = tls_pkg::KIND_NONE;
               n = n + 2'd1;
            end
         end
      end
      op.cnt = n;
   end

   assign cr_pending_in = push ? (is_cr && !end_of_text) : cr_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_pending_ff <= 1'b0;
      end else begin
         cr_pending_ff <= cr_pending_in;
      end
   end

endmodule

// ----- design/tls_fifo.sv -----
// ----------------------------------------------------------------------------
// tls_fifo: operation queue
// short first-in first-out queue between classifier and line counter
// ----------------------------------------------------------------------------
module tls_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tls_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output tls_pkg::op_type head_op
);

   tls_pkg::op_type                    store_ff [tls_pkg::FIFO_DEPTH];
   logic [tls_pkg::FIFO_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tls_pkg::FIFO_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tls_pkg::FIFO_AW:0]          count_ff, count_in;
   logic                               do_pop;

   assign full       = (count_ff == (tls_pkg::FIFO_AW+1)'(tls_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = store_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (tls_pkg::FIFO_AW+1)'(push)
                      - (tls_pkg::FIFO_AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/tls_back.sv -----
// ----------------------------------------------------------------------------
// tls_back: line counter and result register
// runs the queued line closes, keeps saturating counters, drives the result
// ----------------------------------------------------------------------------
module tls_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  tls_pkg::op_type                   head_op,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int W = tls_pkg::CNT_W;

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[W] ? {W{1'b1}} : sum[W-1:0];
   endfunction

   logic [W-1:0] chars_ff, chars_in;
   logic [W-1:0] start_ff, start_in;
   logic [W-1:0] line_ff, line_in;
   logic [1:0]   step_ff, step_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tls_pkg::OUT_W-1:0]     line_number_ff, start_char_ff, body_chars_ff, total_width_ff;
   logic [1:0]                    kind_out_ff;
   logic                          final_ff, last_ff;

   logic         out_free;
   logic         emit;
   logic         count_only;
   logic [1:0]   kind;
   logic         is_none;
   logic         is_last;
   logic [W-1:0] chars_eff;
   logic [W-1:0] end_w;
   logic [W-1:0] width;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_only = head_valid && (head_op.cnt == 2'd0);
   assign emit       = head_valid && (head_op.cnt != 2'd0) && out_free;
   assign kind       = head_op.kind[step_ff];
   assign is_none    = (kind == tls_pkg::KIND_NONE);
   assign is_last    = (step_ff == head_op.cnt - 2'd1);
   assign chars_eff  = (is_none && head_op.inc) ? sat_add(chars_ff, W'(1)) : chars_ff;
   assign end_w      = (kind == tls_pkg::KIND_CRLF) ? W'(2) : (is_none ? W'(0) : W'(1));
   assign width      = sat_add(chars_eff, end_w);
   assign pop        = count_only || (emit && is_last);

   always_comb begin
      chars_in = chars_ff;
      start_in = start_ff;
      line_in  = line_ff;
      step_in  = step_ff;
      if (count_only) begin
         if (head_op.inc) begin
            chars_in = sat_add(chars_ff, W'(1));
         end
      end else if (emit) begin
         step_in = is_last ? 2'd0 : step_ff + 2'd1;
         if (is_none) begin
            // end of text clears all counters
            chars_in = '0;
            start_in = '0;
            line_in  = '0;
         end else begin
            chars_in = (is_last && head_op.inc) ? W'(1) : '0;
            start_in = sat_add(start_ff, width);
            line_in  = sat_add(line_ff, W'(1));
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff     <= '0;
         start_ff     <= '0;
         line_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chars_ff     <= chars_in;
         start_ff     <= start_in;
         line_ff      <= line_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         line_number_ff <= tls_pkg::OUT_W'(line_ff);
         start_char_ff  <= tls_pkg::OUT_W'(start_ff);
         body_chars_ff  <= tls_pkg::OUT_W'(chars_eff);
         total_width_ff <= tls_pkg::OUT_W'(width);
         kind_out_ff    <= kind;
         final_ff       <= is_none;
         last_ff        <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tls_pkg::RSP_DATA_W'({total_width_ff, kind_out_ff, body_chars_ff,
                                             start_char_ff, line_number_ff});
   assign rsp_tuser  = final_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/text_line_splitter_with_metrics.sv -----
// ----------------------------------------------------------------------------
// text_line_splitter_with_metrics: utf-8 line splitter
// splits a byte stream at lf, cr and crlf and reports per-line metrics
//
//   channel  dir  width  contents
//   req      in   8      text byte, tlast = end of text
//   rsp      out  136    line metrics, tuser = final line, tlast = last of request
//
// one request per cycle enters the classifier while the queue has room
// the line counter gives one result per cycle while the result channel can take it
// requests with no result leave the line counter without waiting for an output slot
// a four-entry queue lets the classifier run ahead of a stalled result channel
// synchronous active-high reset clears the pending cr, the counters and the queue
// ----------------------------------------------------------------------------
module text_line_splitter_with_metrics (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // text_byte
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // line_number, start_char, body_chars, ending_kind, total_width, zero fill
   output logic [tls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,  // final_line
   output logic                           rsp_tlast
);

   tls_pkg::op_type push_op;
   tls_pkg::op_type head_op;
   logic            push;
   logic            pop;
   logic            full;
   logic            head_valid;

   tls_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .fifo_full   (full),
      .push        (push),
      .op          (push_op)
   );

   tls_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   tls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // the final line always ends its request
   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("final line not last of request");

   // a line without ending is exactly the final line
   a_none_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[97:96] == tls_pkg::KIND_NONE) == rsp_tuser))
      else $error("ending kind and final flag disagree");

   // a line without ending has width equal to its body
   a_none_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[129:98] == rsp_tdata[95:64]))
      else $error("final line width differs from body");

   // no request is taken while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule
